### hw/rtl/ils_pkg.sv
// shared types and codes for the indexed list store
package ils_pkg;

    // cell position and count fields (POS_W) are sized for depths up to 256
    localparam int POS_W = 9;
    localparam int IDX_W = 5;
    localparam int VAL_W = 32;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_PEEK    = 3'd2,
        OP_INSERT  = 3'd3,
        OP_EXTRACT = 3'd4,
        OP_GET     = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } status_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [VAL_W-1:0]     read_value;
        status_t              status;
        logic [CNT_OUT_W-1:0] count_after;
    } rsp_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             go;
        logic             ins;
        logic             ext;
        logic             rd_en;
        logic [POS_W-1:0] wr_pos;
        logic [POS_W-1:0] rd_pos;
        logic [POS_W-1:0] cnt;
    } cell_cmd_t;

endpackage

### hw/rtl/ils_cell.sv
// one list entry with its shift and read tap logic
module ils_cell
    import ils_pkg::*;
#(
    parameter int POS        = 0,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  cell_cmd_t             cmd,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] tap
);

    localparam logic [POS_W-1:0] MY_POS  = POS_W'(POS);
    localparam logic [POS_W-1:0] MY_NEXT = POS_W'(POS + 1);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [DATA_WIDTH-1:0] tap_reg;
    logic [DATA_WIDTH-1:0] tap_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (MY_POS == cmd.wr_pos)
            begin
                data_next = wr_data;
            end
            else if (MY_POS > cmd.wr_pos && MY_POS <= cmd.cnt)
            begin
                data_next = left_data;
            end
        end
        else if (cmd.ext)
        begin
            if (MY_POS >= cmd.wr_pos && MY_NEXT < cmd.cnt)
            begin
                data_next = right_data;
            end
        end
        tap_next = (cmd.rd_en && cmd.rd_pos == MY_POS) ? data_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            data_reg <= data_next;
            tap_reg  <= tap_next;
        end
    end

    assign data = data_reg;
    assign tap  = tap_reg;

endmodule

### hw/rtl/ils_ctrl.sv
// request decode, count register and response status
module ils_ctrl
    import ils_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  req_t                 req,
    output cell_cmd_t            cmd,
    output status_t              status,
    output logic [CNT_OUT_W-1:0] count_after
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [POS_W-1:0] FULL_CNT = POS_W'(DEPTH);

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    status_t          status_reg;
    status_t          status_next;
    logic [POS_W-1:0] cnt;
    logic [POS_W-1:0] idx;
    logic [POS_W-1:0] cnt_new;

    always_comb
    begin
        cnt         = POS_W'(count_reg);
        idx         = POS_W'(req.index);
        cnt_new     = cnt;
        status_next = ST_OK;
        cmd         = '0;
        cmd.go      = go;
        cmd.cnt     = cnt;
        cmd.wr_pos  = idx;
        cmd.rd_pos  = idx;
        case (req.op)
            OP_PUSH:
            begin
                if (cnt == FULL_CNT)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    // push is an insert at the tail
                    cmd.ins    = 1'b1;
                    cmd.wr_pos = cnt;
                    cnt_new    = cnt + 1'b1;
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (cnt == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_pos = cnt - 1'b1;
                    if (req.op == OP_POP)
                    begin
                        cnt_new = cnt - 1'b1;
                    end
                end
            end
            OP_INSERT:
            begin
                if (cnt == FULL_CNT)
                begin
                    status_next = ST_FULL;
                end
                else if (idx > cnt)
                begin
                    status_next = ST_BADIDX;
                end
                else
                begin
                    cmd.ins = 1'b1;
                    cnt_new = cnt + 1'b1;
                end
            end
            OP_EXTRACT:
            begin
                if (cnt == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if (idx >= cnt)
                begin
                    status_next = ST_BADIDX;
                end
                else
                begin
                    cmd.ext   = 1'b1;
                    cmd.rd_en = 1'b1;
                    cnt_new   = cnt - 1'b1;
                end
            end
            OP_GET:
            begin
                if (idx >= cnt)
                begin
                    status_next = ST_BADIDX;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        count_next = cnt_new[CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= ST_OK;
        end
        else if (go)
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    logic [POS_W-1:0] count_wide;
    assign count_wide  = POS_W'(count_reg);
    assign count_after = count_wide[CNT_OUT_W-1:0];
    assign status      = status_reg;

endmodule

### hw/rtl/indexed_list_store_core.sv
// top level of the indexed list store: controller plus a chain of entry cells
// An ordered list of up to DEPTH words, stored one word per cell in a row of
// cells where each cell can take its left or right neighbor's word. A request
// transaction pushes, pops, peeks, inserts, extracts or reads at an index; an
// insert moves every entry at or above the index up one cell and an extract
// moves every entry above it down one cell, all cells in the same clock. Each
// request returns exactly one response transaction with the word read (zero
// when nothing is read), a status (ok, full, empty, bad index) and the count
// after the request. At the accepting edge the cells shift and each cell
// registers its own word into a read tap if it is the addressed entry, and at
// the next edge the taps are combined into the response register. One request
// is in flight at a time, so the block takes no new request until the last
// one's response is registered; a waiting response holds off new requests
// until it is taken. Entries need no clearing after reset, since only entries
// below the count are ever read.
module indexed_list_store_core
    import ils_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cell_cmd_t             cmd;
    status_t               status;
    logic [CNT_OUT_W-1:0]  count_after;
    logic                  accept;
    logic                  pend_reg;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;
    logic [63:0]           value_wide;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] cell_tap  [DEPTH];
    logic [DATA_WIDTH-1:0] rd_or;
    logic [63:0]           rd_wide;

    // no new request while one is in flight or a response is stuck
    assign req_ready = !pend_reg && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;

    assign value_wide = 64'(req.value);
    assign wr_data    = value_wide[DATA_WIDTH-1:0];

    ils_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (accept),
        .req         (req),
        .cmd         (cmd),
        .status      (status),
        .count_after (count_after)
    );

    // chain of cells; the ends see zero from the missing neighbor
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        if (k == 0)
        begin : g_first
            assign left_data = '0;
        end
        else
        begin : g_left
            assign left_data = cell_data[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_last
            assign right_data = '0;
        end
        else
        begin : g_right
            assign right_data = cell_data[k+1];
        end

        ils_cell #(
            .POS        (k),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .wr_data    (wr_data),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[k]),
            .tap        (cell_tap[k])
        );
    end

    // at most one tap is nonzero, so an or combines them
    always_comb
    begin
        rd_or = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            rd_or = rd_or | cell_tap[k];
        end
    end

    assign rd_wide = 64'(rd_or);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= accept;
            if (pend_reg)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // response payload register, loaded once the taps hold the read word
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            rsp_reg.read_value  <= rd_wide[VAL_W-1:0];
            rsp_reg.status      <= status;
            rsp_reg.count_after <= count_after;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
